// ===== src/sha1_message_digest_assert.svh =====
// ---------------------------------------------------------------------------
// SHA-1 message digest: assertion macros
// Short forms for the clocked, reset-qualified properties of the checker.
// ---------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SHA1MD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SHA1MD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sha1md_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-1 message digest: shared package
// Types, constants and round functions used by the front queue and the engine.
// ---------------------------------------------------------------------------
package sha1md_pkg;

   // Input queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Block and digest geometry.
   localparam int BLOCK_WORDS  = 16;
   localparam int LEN_SLOT     = 14;
   localparam int DIGEST_WORDS = 5;
   localparam int LAST_ROUND   = 79;
   localparam int LAST_BYTE    = 63;

   // Initial chaining values.
   localparam logic [31:0] IV [DIGEST_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   // Round constants, one for each group of twenty rounds.
   localparam logic [31:0] K_CH  = 32'h5a827999;
   localparam logic [31:0] K_PA1 = 32'h6ed9eba1;
   localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
   localparam logic [31:0] K_PA2 = 32'hca62c1d6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // One queued item after classification.
   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       is_end;
   } item_type;

   // Head of the queue as seen by the engine.
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ZERO,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   // Where the engine continues once a compression has been folded in.
   typedef enum logic [1:0] {
      RET_BYTES,
      RET_PAD,
      RET_DIGEST
   } ret_type;

   // Logical function of round t.
   function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (t < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (t < 7'd40) begin
         f = b ^ c ^ d;
      end else if (t < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   // Additive constant of round t.
   function automatic logic [31:0] round_k(input logic [6:0] t);
      logic [31:0] k;
      if (t < 7'd20) begin
         k = K_CH;
      end else if (t < 7'd40) begin
         k = K_PA1;
      end else if (t < 7'd60) begin
         k = K_MAJ;
      end else begin
         k = K_PA2;
      end
      return k;
   endfunction

endpackage

// ===== src/sha1md_front.sv =====
// ---------------------------------------------------------------------------
// SHA-1 message digest: front queue
// Accepts input beats, drops beats that carry neither a byte nor an end mark,
// and queues the rest for the compression engine.
// ---------------------------------------------------------------------------
module sha1md_front import sha1md_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output head_type head,
   input  logic     pop
);

   item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;
   logic                    push;
   logic                    take;

   // A beat with no byte and no end mark has no effect and is not queued.
   assign in_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push     = in_valid && in_ready && (in_item.has_byte || in_item.is_end);
   assign take     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== src/sha1md_back.sv =====
// ---------------------------------------------------------------------------
// SHA-1 message digest: compression engine
// Packs bytes into a 16-word shifting schedule window, pads the final block,
// runs 80 rounds at one per cycle and emits the five digest words.
// ---------------------------------------------------------------------------
module sha1md_back import sha1md_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  head_type    head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_word,
   output logic [2:0]  rsp_index,
   output logic        rsp_last
);

   state_type   state_ff, state_in;
   ret_type     ret_ff, ret_in;
   logic        pend_end_ff;
   logic [63:0] len_ff;
   logic [23:0] acc_ff;
   logic [4:0]  fill_ff;
   logic [31:0] win_ff [BLOCK_WORDS];
   logic [31:0] rw_ff [DIGEST_WORDS];
   logic [31:0] chain_ff [DIGEST_WORDS];
   logic [6:0]  round_ff;
   logic [2:0]  out_idx_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_word_ff;
   logic [2:0]  rsp_index_ff;
   logic        rsp_last_ff;

   // Control strobes from the output decode.
   logic        byte_take;
   logic        shift_en;
   logic [31:0] shift_word;
   logic        start_rnd;
   logic        round_step;
   logic        chain_add;
   logic        out_load;
   logic        msg_done;

   // Datapath helpers.
   item_type    cur;
   logic [5:0]  pos;
   logic [31:0] byte_word;
   logic [31:0] pad_word;
   logic [31:0] sched_mix;
   logic [31:0] sched_word;
   logic [31:0] rot_a;
   logic [31:0] rot_b;
   logic [31:0] round_sum;
   logic        slot_free;
   logic        idx_last;

   assign cur       = head.item;
   assign pos       = len_ff[8:3];
   assign byte_word = {acc_ff, cur.data};
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign idx_last  = (out_idx_ff == 3'(DIGEST_WORDS - 1));

   // Partial word closed with the pad byte and zero filled.
   always_comb begin
      case (len_ff[4:3])
         2'd0:    pad_word = {PAD_BYTE, 24'h0};
         2'd1:    pad_word = {acc_ff[7:0], PAD_BYTE, 16'h0};
         2'd2:    pad_word = {acc_ff[15:0], PAD_BYTE, 8'h0};
         2'd3:    pad_word = {acc_ff[23:0], PAD_BYTE};
         default: pad_word = {PAD_BYTE, 24'h0};
      endcase
   end

   // Message schedule and round arithmetic; win_ff[0] holds the current word.
   assign sched_mix  = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign sched_word = {sched_mix[30:0], sched_mix[31]};
   assign rot_a      = {rw_ff[0][26:0], rw_ff[0][31:27]};
   assign rot_b      = {rw_ff[1][1:0], rw_ff[1][31:2]};
   assign round_sum  = rot_a + round_f(round_ff, rw_ff[1], rw_ff[2], rw_ff[3])
                     + rw_ff[4] + round_k(round_ff) + win_ff[0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               if (cur.has_byte && (pos == 6'(LAST_BYTE))) begin
                  state_in = ST_ROUND;
               end else if (cur.is_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            state_in = ST_ZERO;
         end
         ST_ZERO: begin
            if (fill_ff == 5'(BLOCK_WORDS)) begin
               state_in = ST_ROUND;
            end else if (fill_ff == 5'(LEN_SLOT)) begin
               state_in = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            state_in = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == 7'(LAST_ROUND)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            case (ret_ff)
               RET_BYTES:  state_in = pend_end_ff ? ST_PAD : ST_IDLE;
               RET_PAD:    state_in = ST_ZERO;
               RET_DIGEST: state_in = ST_OUT;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (slot_free && idx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control strobes for the datapath.
   always_comb begin
      pop        = 1'b0;
      byte_take  = 1'b0;
      shift_en   = 1'b0;
      shift_word = '0;
      start_rnd  = 1'b0;
      ret_in     = ret_ff;
      round_step = 1'b0;
      chain_add  = 1'b0;
      out_load   = 1'b0;
      msg_done   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (cur.has_byte) begin
                  byte_take = 1'b1;
                  if (pos[1:0] == 2'd3) begin
                     shift_en   = 1'b1;
                     shift_word = byte_word;
                  end
                  if (pos == 6'(LAST_BYTE)) begin
                     start_rnd = 1'b1;
                     ret_in    = RET_BYTES;
                  end
               end
            end
         end
         ST_PAD: begin
            shift_en   = 1'b1;
            shift_word = pad_word;
         end
         ST_ZERO: begin
            if (fill_ff == 5'(BLOCK_WORDS)) begin
               start_rnd = 1'b1;
               ret_in    = RET_PAD;
            end else if (fill_ff != 5'(LEN_SLOT)) begin
               shift_en = 1'b1;
            end
         end
         ST_LEN_HI: begin
            shift_en   = 1'b1;
            shift_word = len_ff[63:32];
         end
         ST_LEN_LO: begin
            shift_en   = 1'b1;
            shift_word = len_ff[31:0];
            start_rnd  = 1'b1;
            ret_in     = RET_DIGEST;
         end
         ST_ROUND: begin
            round_step = 1'b1;
         end
         ST_ADD: begin
            chain_add = 1'b1;
         end
         ST_OUT: begin
            if (slot_free) begin
               out_load = 1'b1;
               msg_done = idx_last;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= RET_BYTES;
         pend_end_ff  <= 1'b0;
         len_ff       <= '0;
         fill_ff      <= '0;
         round_ff     <= '0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= IV[i];
         end
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         if (start_rnd && (state_ff == ST_IDLE)) begin
            pend_end_ff <= cur.is_end;
         end
         // Bit length, cleared once the last digest word is loaded.
         if (msg_done) begin
            len_ff <= '0;
         end else if (byte_take) begin
            len_ff <= len_ff + 64'd8;
         end
         if (start_rnd) begin
            fill_ff <= '0;
         end else if (shift_en) begin
            fill_ff <= fill_ff + 5'd1;
         end
         if (start_rnd) begin
            round_ff <= '0;
         end else if (round_step) begin
            round_ff <= round_ff + 7'd1;
         end
         // Chaining words fold in each compression and restart per message.
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            if (msg_done) begin
               chain_ff[i] <= IV[i];
            end else if (chain_add) begin
               chain_ff[i] <= chain_ff[i] + rw_ff[i];
            end
         end
         if (out_load) begin
            out_idx_ff <= idx_last ? 3'd0 : out_idx_ff + 3'd1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: byte packer, schedule window, working words, result.
   always_ff @(posedge clock) begin
      if (byte_take) begin
         acc_ff <= byte_word[23:0];
      end
      if (shift_en || round_step) begin
         for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
            win_ff[j] <= win_ff[j+1];
         end
         win_ff[BLOCK_WORDS-1] <= round_step ? sched_word : shift_word;
      end
      if (start_rnd) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            rw_ff[i] <= chain_ff[i];
         end
      end else if (round_step) begin
         rw_ff[0] <= round_sum;
         rw_ff[1] <= rw_ff[0];
         rw_ff[2] <= rot_b;
         rw_ff[3] <= rw_ff[2];
         rw_ff[4] <= rw_ff[3];
      end
      if (out_load) begin
         rsp_word_ff  <= chain_ff[out_idx_ff];
         rsp_index_ff <= out_idx_ff;
         rsp_last_ff  <= idx_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== src/sha1_message_digest.sv =====
// ---------------------------------------------------------------------------
// SHA-1 message digest
// Byte-stream SHA-1 with a small input queue in front of a round engine.
// ---------------------------------------------------------------------------
// Input beats enter a four-entry queue at one beat per cycle while it has
// room; beats with neither a byte nor an end mark are dropped there. The
// engine takes one queued byte per cycle while idle and, on the 64th byte
// of a block, runs a compression (80 rounds at one per cycle in the single
// round unit, then the chaining add) before it takes bytes again.
// After an end mark the engine shifts in the padding word, the zero words
// and the two length words, runs one or two compressions, and then emits
// the digest words while the result side is ready. The five digest words
// leave most significant first, the last one marked with tlast.
module sha1_message_digest import sha1md_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
   output logic        rsp_tlast    // last_word
);

   item_type    in_item;
   head_type    head;
   logic        pop;
   logic [31:0] rsp_word;
   logic [2:0]  rsp_index;

   assign in_item.data     = req_tdata;
   assign in_item.has_byte = req_tuser;
   assign in_item.is_end   = req_tlast;

   sha1md_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .head     (head),
      .pop      (pop)
   );

   sha1md_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_word  (rsp_word),
      .rsp_index (rsp_index),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, rsp_index, rsp_word};

endmodule

// ===== src/sha1md_checker.sv =====
// ---------------------------------------------------------------------------
// SHA-1 message digest: port checker
// Watches the top-level ports for digest framing and result-side behavior.
// ---------------------------------------------------------------------------
`include "sha1_message_digest_assert.svh"

module sha1md_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // The last mark sits on the fifth digest word and nowhere else.
   `SHA1MD_ASSERT_IMP(a_last_on_fifth, rsp_tvalid, rsp_tlast == (rsp_tdata[34:32] == 3'd4), "tlast does not match word index four")

   // Word index stays in range and the fill bits are zero.
   `SHA1MD_ASSERT_IMP(a_index_range, rsp_tvalid, (rsp_tdata[34:32] <= 3'd4) && (rsp_tdata[39:35] == 5'd0), "bad word index or fill bits")

   // A stalled result beat holds.
   `SHA1MD_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result beat changed while stalled")

   // Coming out of reset the queue is open and no result is pending.
   `SHA1MD_ASSERT_IMP(a_reset_clean, $past(reset), req_tready && !rsp_tvalid, "block not clean after reset")

endmodule

bind sha1_message_digest sha1md_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/sha1_digest_checker.sv =====
// ---------------------------------------------------------------------------
// SHA-1 message digest: stream checker
// Watches both channels, predicts the digest beats and compares them.
// ---------------------------------------------------------------------------
// Every accepted input beat is fed to a software SHA-1 that collects
// big-endian message words, compresses each full block and pads at the end
// mark. The five digest words of a closed message are queued in order.
// Each accepted result beat is then checked against the oldest queued word.
module sha1_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
   input  logic        rsp_tlast,   // last_word
   output int          fail_count,
   output int          words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] CHAIN_START [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };
   localparam logic [7:0] PAD_MARK = 8'h80;

   // One expected digest beat.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  position;
      logic        last;
   } digest_beat_type;

   logic [31:0]     msg_block [16];
   logic [31:0]     chain [5];
   logic [63:0]     message_bits;
   digest_beat_type digest_words_due [$];
   int              mismatches = 0;

   assign fail_count    = mismatches;
   assign words_pending = digest_words_due.size();

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Run the 80 rounds over the current block and fold them into the chain.
   function automatic void sha1_fold_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, sum;
      for (int t = 0; t < 16; t++) sched[t] = msg_block[t];
      for (int t = 16; t < 80; t++) begin
         sched[t] = rotate_left(sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16], 1);
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5a827999;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ed9eba1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8f1bbcdc;
         end else begin
            f = b ^ c ^ d;
            k = 32'hca62c1d6;
         end
         sum = rotate_left(a, 5) + f + e + k + sched[t];
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = sum;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   // Bytes land big-endian; the first byte of a word clears the rest of it.
   function automatic void place_byte(input logic [5:0] pos, input logic [7:0] value);
      int lane;
      lane = 3 - int'(pos[1:0]);
      if (pos[1:0] == 2'd0) msg_block[pos[5:2]] = '0;
      msg_block[pos[5:2]][8*lane +: 8] = value;
   endfunction

   function automatic void start_message();
      for (int i = 0; i < 5; i++) chain[i] = CHAIN_START[i];
      message_bits = '0;
   endfunction

   // Pad, append the bit length, compress and queue the five digest words.
   function automatic void close_message();
      logic [5:0]      pos;
      digest_beat_type beat;
      pos = message_bits[8:3];
      place_byte(pos, PAD_MARK);
      for (int i = int'(pos[5:2]) + 1; i < 16; i++) msg_block[i] = '0;
      // No room left for the length: it goes into an extra block.
      if (pos >= 6'd56) begin
         sha1_fold_block();
         for (int i = 0; i < 16; i++) msg_block[i] = '0;
      end
      msg_block[14] = message_bits[63:32];
      msg_block[15] = message_bits[31:0];
      sha1_fold_block();
      for (int i = 0; i < 5; i++) begin
         beat.word        = chain[i];
         beat.position    = 3'(i);
         beat.last        = (i == 4);
         digest_words_due = {digest_words_due, beat};
      end
      start_message();
   endfunction

   // Follow both channels on every rising edge.
   always @(posedge clock) begin
      logic [5:0]      pos;
      digest_beat_type want;
      if (reset) begin
         start_message();
         digest_words_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_words_due.size() == 0) begin
               $display("%0t: unexpected digest beat %h index %0d last %0b", $time,
                        rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
               mismatches++;
            end else begin
               want = digest_words_due.pop_front();
               if (rsp_tdata[31:0] !== want.word) begin
                  $display("%0t: digest_word mismatch: expected %h, actual %h", $time,
                           want.word, rsp_tdata[31:0]);
                  mismatches++;
               end
               if (rsp_tdata[34:32] !== want.position) begin
                  $display("%0t: word_index mismatch: expected %0d, actual %0d", $time,
                           want.position, rsp_tdata[34:32]);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_word mismatch: expected %0b, actual %0b", $time,
                           want.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               pos = message_bits[8:3];
               place_byte(pos, req_tdata);
               message_bits += 64'd8;
               if (pos == 6'd63) sha1_fold_block();
            end
            if (req_tlast) close_message();
         end
      end
   end

endmodule

// ===== tb/sha1_message_digest_tb.sv =====
// ---------------------------------------------------------------------------
// SHA-1 message digest: testbench top
// Drives byte messages into the block and gives the verdict from the checker.
// ---------------------------------------------------------------------------
// A short directed part covers the empty message, dropped beats, a byte
// with the end mark, an end mark without a byte and extreme byte values.
// Random messages follow in three phases with different idle patterns,
// lengths mostly short, some near padding and block boundaries. In the last
// phase the receiver holds off for a long stretch so the block backs up.
module sha1_message_digest_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 400;
   localparam int PHASE_ITEMS  = 30;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   int checker_fails;
   int words_pending;
   int tx_idle_pct   = 30;
   int rx_idle_pct   = 73;
   int hold_requests = 0;
   int holds_served  = 0;
   int items_sent    = 0;
   int cycle_count   = 0;

   sha1_message_digest DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sha1_digest_checker digest_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (checker_fails),
      .words_pending (words_pending)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: the run never goes past the cycle limit.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sha1_message_digest test failed");
      $finish;
   end

   // Result side: random back-pressure, or a long hold-off when requested.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offer one beat, with random idle cycles ahead of it, until it is taken.
   task automatic send_item(input logic [7:0] value, input logic present,
                            input logic closing);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= present;
      req_tlast  <= closing;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (present || closing) items_sent++;
   endtask

   // A message of random bytes with the odd dropped beat mixed in. The end
   // mark rides on the last byte or comes in a beat of its own.
   task automatic send_message(input int len);
      logic end_on_byte;
      end_on_byte = (len > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // Mostly short messages; some near one block length so that both
   // padding layouts and two-block messages come up.
   task automatic run_random_phase();
      int start_items;
      int msgs;
      int pick;
      int len;
      start_items = items_sent;
      msgs = 0;
      while (items_sent - start_items < PHASE_ITEMS || msgs < 3) begin
         pick = $urandom_range(9);
         if (pick < 9) len = $urandom_range(12);
         else len = $urandom_range(65, 54);
         send_message(len);
         msgs++;
      end
   endtask

   // Stop offering and wait until every predicted digest word has arrived.
   task automatic wait_for_digests();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (words_pending != 0);
      @(posedge clock);
   endtask

   // Stimulus and verdict.
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty message, with stray data that must be ignored.
      send_item(8'hff, 1'b0, 1'b1);
      // A beat with neither byte nor end mark is dropped.
      send_item(8'ha5, 1'b0, 1'b0);
      // The classic three-byte message, end mark on the last byte.
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // Single zero byte carrying the end mark.
      send_item(8'h00, 1'b1, 1'b1);
      // Byte, dropped beat, then an end mark without a byte.
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // Alternating extremes in one word.
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h7f, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'hfe, 1'b1, 1'b1);
      // Two empty messages back to back.
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b1);
      wait_for_digests();

      run_random_phase();
      wait_for_digests();

      tx_idle_pct = 73;
      rx_idle_pct = 30;
      run_random_phase();
      wait_for_digests();

      // No idling; the receiver stalls while short messages pile up behind it.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_requests++;
      send_item(8'h3c, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      send_message(3);
      run_random_phase();
      wait_for_digests();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (checker_fails == 0 && words_pending == 0) begin
         $display("sha1_message_digest test passed");
      end else begin
         $display("sha1_message_digest test failed");
      end
      $finish;
   end

endmodule

// ===== sha1_message_digest.f =====
+incdir+src
src/sha1md_pkg.sv
src/sha1md_front.sv
src/sha1md_back.sv
src/sha1_message_digest.sv
src/sha1md_checker.sv
tb/sha1_digest_checker.sv
tb/sha1_message_digest_tb.sv
